// ===== rtl/core/i2cms_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// i2cms_pkg
// shared types and codes for the i2c master transfer sequencer
// ----------------------------------------------------------------------------
package i2cms_pkg;

	localparam int unsigned AddrWidth  = 7;
	localparam int unsigned ByteWidth  = 8;
	localparam int unsigned CountWidth = 8;

	// request codes
	typedef enum logic [1:0] {
		FN_ABORT = 2'd0,
		FN_START = 2'd1,
		FN_EVENT = 2'd2,
		FN_RSVD  = 2'd3
	} func_t;

	// peripheral bus states
	localparam logic [2:0] BS_IDLE    = 3'd0;
	localparam logic [2:0] BS_START   = 3'd1;
	localparam logic [2:0] BS_ADDR    = 3'd2;
	localparam logic [2:0] BS_ADDRACK = 3'd3;
	localparam logic [2:0] BS_DATA    = 3'd4;
	localparam logic [2:0] BS_DATAACK = 3'd5;

	// bus commands
	localparam logic [2:0] CMD_NONE  = 3'd0;
	localparam logic [2:0] CMD_START = 3'd1;
	localparam logic [2:0] CMD_STOP  = 3'd2;
	localparam logic [2:0] CMD_ACK   = 3'd3;
	localparam logic [2:0] CMD_NACK  = 3'd4;
	localparam logic [2:0] CMD_ABORT = 3'd5;

	// result codes kept in state
	typedef enum logic [1:0] {
		RES_OK    = 2'd0,
		RES_ANACK = 2'd1,
		RES_DNACK = 2'd2,
		RES_HANG  = 2'd3
	} res_t;

	// reported status, one wider than the result code
	localparam logic [2:0] ST_BUSY = 3'd4;

	localparam logic RW_WRITE = 1'b0;
	localparam logic RW_READ  = 1'b1;

	typedef enum logic [2:0] {
		PH_IDLE  = 3'd0,
		PH_START = 3'd1,
		PH_WADDR = 3'd2,
		PH_WDATA = 3'd3,
		PH_READ  = 3'd4,
		PH_STOP  = 3'd5
	} phase_t;

	// what one word does to the sequence
	typedef enum logic [3:0] {
		ACT_REJECT,
		ACT_START_OK,
		ACT_START_ERR,
		ACT_WAIT,
		ACT_SEND_WADDR,
		ACT_SEND_RADDR,
		ACT_STOP_OK,
		ACT_ANACK,
		ACT_DNACK,
		ACT_TX_DATA,
		ACT_RESTART,
		ACT_RX_CMD,
		ACT_RX_BYTE,
		ACT_STOP_DONE,
		ACT_ERROR
	} act_t;

	typedef struct packed {
		phase_t                 phase;
		logic                   active;
		logic                   write_phase_done;
		logic [CountWidth-1:0]  byte_position;
		res_t                   result_code;
		logic [AddrWidth-1:0]   device_address;
		logic [CountWidth-1:0]  bytes_to_write;
		logic [CountWidth-1:0]  bytes_to_read;
	} seq_state_t;

	typedef struct packed {
		logic [1:0]             func;
		logic [2:0]             bus_state;
		logic                   bus_nacked;
		logic                   stop_seen;
		logic [AddrWidth-1:0]   target_address;
		logic [CountWidth-1:0]  write_count;
		logic [CountWidth-1:0]  read_count;
		logic [ByteWidth-1:0]   tx_byte;
		logic [ByteWidth-1:0]   rx_byte;
	} seq_in_t;

	typedef struct packed {
		logic [2:0]             bus_cmd;
		logic                   tx_valid;
		logic [ByteWidth-1:0]   tx_data;
		logic                   flush_rx;
		logic                   rx_valid;
		logic [ByteWidth-1:0]   rx_data;
		logic [CountWidth-1:0]  rx_index;
		logic [CountWidth-1:0]  position;
		logic                   done_res;
		logic [2:0]             status;
		logic                   busy_res;
	} seq_res_t;

endpackage

// ===== rtl/core/i2c_master_transfer_sequencer_unit.sv =====
`timescale 1ns / 1ps
// a word taken into the input register passes through the step logic into the result register
// throughput: one word per cycle, no bubbles while the output side takes words
// the only loop is the sequence state feeding back through one step of logic
// reset: arst_n clears both stage valids and the sequence state (phase idle,
// no transfer active, counts and position zero, result ok) asynchronously
// ----------------------------------------------------------------------------
// i2c_master_transfer_sequencer_unit
// sequences one i2c master write-then-read transfer from requests and bus
// events, one result word per input word
// ----------------------------------------------------------------------------
module i2c_master_transfer_sequencer_unit (
	input  logic       clk,
	input  logic       arst_n,

	// input channel
	input  logic       in_valid,
	output logic       in_stall,
	input  logic [1:0] func,
	input  logic [2:0] bus_state,
	input  logic       bus_nacked,
	input  logic       stop_seen,
	input  logic [6:0] target_address,
	input  logic [7:0] write_count,
	input  logic [7:0] read_count,
	input  logic [7:0] tx_byte,
	input  logic [7:0] rx_byte,

	// result channel
	output logic       out_valid,
	input  logic       out_stall,
	output logic [2:0] bus_cmd,
	output logic       tx_valid,
	output logic [7:0] tx_data,
	output logic       flush_rx,
	output logic       rx_valid,
	output logic [7:0] rx_data,
	output logic [7:0] rx_index,
	output logic [7:0] position,
	output logic       done_res,
	output logic [2:0] status,
	output logic       busy_res
);

	// input register stage
	logic                  valid_s1;
	i2cms_pkg::seq_in_t    word_s1;

	// result register stage
	logic                  valid_s2;
	i2cms_pkg::seq_res_t   res_s2;

	// sequence state and the step outputs
	i2cms_pkg::seq_state_t state_q;
	i2cms_pkg::seq_state_t state_nxt;
	i2cms_pkg::seq_res_t   res_nxt;

	logic                  load_s2;
	logic                  load_s1;

	// the result register can take a new word when empty or being emptied
	assign load_s2  = !valid_s2 || !out_stall;
	// the input register holds its word only while it cannot move on
	assign in_stall = valid_s1 && !load_s2;
	assign load_s1  = in_valid && !in_stall;

	// input stage: payload needs no reset
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (!in_stall) begin
			valid_s1 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (load_s1) begin
			word_s1.func           <= func;
			word_s1.bus_state      <= bus_state;
			word_s1.bus_nacked     <= bus_nacked;
			word_s1.stop_seen      <= stop_seen;
			word_s1.target_address <= target_address;
			word_s1.write_count    <= write_count;
			word_s1.read_count     <= read_count;
			word_s1.tx_byte        <= tx_byte;
			word_s1.rx_byte        <= rx_byte;
		end
	end

	// one sequencing step, purely combinational
	i2cms_step u_step (
		.state     (state_q),
		.word      (word_s1),
		.state_nxt (state_nxt),
		.res       (res_nxt)
	);

	// sequence state advances exactly when a word leaves the input stage
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q.phase            <= i2cms_pkg::PH_IDLE;
			state_q.active           <= 1'b0;
			state_q.write_phase_done <= 1'b0;
			state_q.byte_position    <= '0;
			state_q.result_code      <= i2cms_pkg::RES_OK;
			state_q.device_address   <= '0;
			state_q.bytes_to_write   <= '0;
			state_q.bytes_to_read    <= '0;
		end else if (valid_s1 && load_s2) begin
			state_q <= state_nxt;
		end
	end

	// result stage
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s2 <= 1'b0;
		end else if (load_s2) begin
			valid_s2 <= valid_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (valid_s1 && load_s2) begin
			res_s2 <= res_nxt;
		end
	end

	assign out_valid = valid_s2;
	assign bus_cmd   = res_s2.bus_cmd;
	assign tx_valid  = res_s2.tx_valid;
	assign tx_data   = res_s2.tx_data;
	assign flush_rx  = res_s2.flush_rx;
	assign rx_valid  = res_s2.rx_valid;
	assign rx_data   = res_s2.rx_data;
	assign rx_index  = res_s2.rx_index;
	assign position  = res_s2.position;
	assign done_res  = res_s2.done_res;
	assign status    = res_s2.status;
	assign busy_res  = res_s2.busy_res;

	// a finished transfer is never still busy
	a_done_not_busy: assert property (@(posedge clk) disable iff (!arst_n)
		valid_s2 && res_s2.done_res |-> !res_s2.busy_res)
		else $error("done reported with transfer still busy");

	// a rejected start only happens while a transfer runs
	a_reject_busy: assert property (@(posedge clk) disable iff (!arst_n)
		valid_s2 && res_s2.status == i2cms_pkg::ST_BUSY |-> res_s2.busy_res)
		else $error("busy rejection without an active transfer");

	// an abort never carries a byte to transmit or a flush
	a_abort_clean: assert property (@(posedge clk) disable iff (!arst_n)
		valid_s2 && res_s2.bus_cmd == i2cms_pkg::CMD_ABORT
		|-> !res_s2.tx_valid && !res_s2.flush_rx)
		else $error("abort word carries transmit data");

	// sequence state only moves when a word passes to the result stage
	a_state_hold: assert property (@(posedge clk) disable iff (!arst_n)
		!(valid_s1 && load_s2) |=> $stable(state_q))
		else $error("sequence state changed without a word");

	// no transfer active means the phase is idle
	a_idle_inactive: assert property (@(posedge clk) disable iff (!arst_n)
		!state_q.active |-> state_q.phase == i2cms_pkg::PH_IDLE)
		else $error("phase left idle with no transfer active");

endmodule

// ===== rtl/core/i2cms_step.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// i2cms_step
// one step of the transfer sequence: decode, next state and result word
// ----------------------------------------------------------------------------
module i2cms_step (
	input  i2cms_pkg::seq_state_t state,
	input  i2cms_pkg::seq_in_t    word,
	output i2cms_pkg::seq_state_t state_nxt,
	output i2cms_pkg::seq_res_t   res
);

	i2cms_pkg::act_t                         act;
	logic [i2cms_pkg::CountWidth-1:0]        pos_inc;
	logic [i2cms_pkg::CountWidth:0]          pos_inc_wide;
	logic                                    bs_idle, bs_start, bs_addr, bs_addrack;
	logic                                    bs_data, bs_dataack;
	logic [i2cms_pkg::ByteWidth-1:0]         addr_w, addr_r;

	// exact state matches, with a clear nacked bit required except in the two ack states
	assign bs_idle    = (word.bus_state == i2cms_pkg::BS_IDLE)    && !word.bus_nacked;
	assign bs_start   = (word.bus_state == i2cms_pkg::BS_START)   && !word.bus_nacked;
	assign bs_addr    = (word.bus_state == i2cms_pkg::BS_ADDR)    && !word.bus_nacked;
	assign bs_addrack = (word.bus_state == i2cms_pkg::BS_ADDRACK);
	assign bs_data    = (word.bus_state == i2cms_pkg::BS_DATA)    && !word.bus_nacked;
	assign bs_dataack = (word.bus_state == i2cms_pkg::BS_DATAACK);

	assign pos_inc_wide = {1'b0, state.byte_position}
		+ {{i2cms_pkg::CountWidth{1'b0}}, 1'b1};
	assign pos_inc      = pos_inc_wide[i2cms_pkg::CountWidth-1:0];
	assign addr_w       = {state.device_address, i2cms_pkg::RW_WRITE};
	assign addr_r       = {state.device_address, i2cms_pkg::RW_READ};

	// decode
	always_comb begin
		act = i2cms_pkg::ACT_ERROR;
		case (word.func)
			i2cms_pkg::FN_START: begin
				if (state.active)
					act = i2cms_pkg::ACT_REJECT;
				else if (state.phase == i2cms_pkg::PH_IDLE && bs_idle)
					act = i2cms_pkg::ACT_START_OK;
				else
					act = i2cms_pkg::ACT_START_ERR;
			end
			i2cms_pkg::FN_EVENT: begin
				case (state.phase)
					i2cms_pkg::PH_START: begin
						if (!bs_start)
							act = i2cms_pkg::ACT_ERROR;
						else if (!state.write_phase_done && state.bytes_to_write != '0)
							act = i2cms_pkg::ACT_SEND_WADDR;
						else if (state.bytes_to_read != '0)
							act = i2cms_pkg::ACT_SEND_RADDR;
						else
							act = i2cms_pkg::ACT_STOP_OK;
					end
					i2cms_pkg::PH_WADDR: begin
						if (bs_addr)
							act = i2cms_pkg::ACT_WAIT;
						else if (bs_addrack && word.bus_nacked)
							act = i2cms_pkg::ACT_ANACK;
						else if (bs_addrack)
							act = i2cms_pkg::ACT_TX_DATA;
						else
							act = i2cms_pkg::ACT_ERROR;
					end
					i2cms_pkg::PH_WDATA: begin
						if (bs_data)
							act = i2cms_pkg::ACT_WAIT;
						else if (bs_dataack && word.bus_nacked)
							act = i2cms_pkg::ACT_DNACK;
						else if (bs_dataack) begin
							if (state.byte_position < state.bytes_to_write)
								act = i2cms_pkg::ACT_TX_DATA;
							else if (state.bytes_to_read != '0)
								act = i2cms_pkg::ACT_RESTART;
							else
								act = i2cms_pkg::ACT_STOP_OK;
						end else
							act = i2cms_pkg::ACT_ERROR;
					end
					i2cms_pkg::PH_READ: begin
						if (bs_addr)
							act = i2cms_pkg::ACT_WAIT;
						else if (bs_addrack && word.bus_nacked)
							act = i2cms_pkg::ACT_ANACK;
						else if (bs_addrack)
							act = i2cms_pkg::ACT_WAIT;
						else if (bs_data)
							act = i2cms_pkg::ACT_RX_CMD;
						else if (bs_dataack && !word.bus_nacked)
							act = i2cms_pkg::ACT_RX_BYTE;
						else
							act = i2cms_pkg::ACT_ERROR;
					end
					i2cms_pkg::PH_STOP: begin
						if (bs_idle || word.stop_seen)
							act = i2cms_pkg::ACT_STOP_DONE;
						else
							act = i2cms_pkg::ACT_ERROR;
					end
					default: act = i2cms_pkg::ACT_ERROR;
				endcase
			end
			default: act = i2cms_pkg::ACT_ERROR;
		endcase
	end

	// next state
	always_comb begin
		state_nxt = state;
		case (act)
			i2cms_pkg::ACT_START_OK, i2cms_pkg::ACT_START_ERR: begin
				state_nxt.device_address   = word.target_address;
				state_nxt.bytes_to_write   = word.write_count;
				state_nxt.bytes_to_read    = word.read_count;
				state_nxt.byte_position    = '0;
				state_nxt.write_phase_done = 1'b0;
				if (act == i2cms_pkg::ACT_START_OK) begin
					state_nxt.result_code = i2cms_pkg::RES_OK;
					state_nxt.active      = 1'b1;
					state_nxt.phase       = i2cms_pkg::PH_START;
				end else begin
					// bus not idle on start: the new transfer hangs at once
					state_nxt.result_code = i2cms_pkg::RES_HANG;
					state_nxt.active      = 1'b0;
					state_nxt.phase       = i2cms_pkg::PH_IDLE;
				end
			end
			i2cms_pkg::ACT_SEND_WADDR: state_nxt.phase = i2cms_pkg::PH_WADDR;
			i2cms_pkg::ACT_SEND_RADDR: state_nxt.phase = i2cms_pkg::PH_READ;
			i2cms_pkg::ACT_STOP_OK: begin
				state_nxt.result_code = i2cms_pkg::RES_OK;
				state_nxt.phase       = i2cms_pkg::PH_STOP;
			end
			i2cms_pkg::ACT_ANACK: begin
				state_nxt.result_code = i2cms_pkg::RES_ANACK;
				state_nxt.phase       = i2cms_pkg::PH_STOP;
			end
			i2cms_pkg::ACT_DNACK: begin
				state_nxt.result_code = i2cms_pkg::RES_DNACK;
				state_nxt.phase       = i2cms_pkg::PH_STOP;
			end
			i2cms_pkg::ACT_TX_DATA: begin
				state_nxt.phase         = i2cms_pkg::PH_WDATA;
				state_nxt.byte_position = pos_inc;
			end
			i2cms_pkg::ACT_RESTART: begin
				state_nxt.write_phase_done = 1'b1;
				state_nxt.byte_position    = '0;
				state_nxt.phase            = i2cms_pkg::PH_START;
			end
			i2cms_pkg::ACT_RX_BYTE: begin
				state_nxt.byte_position = pos_inc;
				if (pos_inc == state.bytes_to_read) begin
					state_nxt.result_code = i2cms_pkg::RES_OK;
					state_nxt.phase       = i2cms_pkg::PH_STOP;
				end
			end
			i2cms_pkg::ACT_STOP_DONE: begin
				state_nxt.phase  = i2cms_pkg::PH_IDLE;
				state_nxt.active = 1'b0;
			end
			i2cms_pkg::ACT_ERROR: begin
				state_nxt.phase  = i2cms_pkg::PH_IDLE;
				state_nxt.active = 1'b0;
				if (state.active)
					state_nxt.result_code = i2cms_pkg::RES_HANG;
			end
			default: state_nxt = state;
		endcase
	end

	// result word
	always_comb begin
		res          = '0;
		res.bus_cmd  = i2cms_pkg::CMD_NONE;
		case (act)
			i2cms_pkg::ACT_START_OK, i2cms_pkg::ACT_RESTART:
				res.bus_cmd = i2cms_pkg::CMD_START;
			i2cms_pkg::ACT_START_ERR: begin
				res.bus_cmd  = i2cms_pkg::CMD_ABORT;
				res.done_res = 1'b1;
			end
			i2cms_pkg::ACT_SEND_WADDR: begin
				res.tx_valid = 1'b1;
				res.tx_data  = addr_w;
			end
			i2cms_pkg::ACT_SEND_RADDR: begin
				res.flush_rx = 1'b1;
				res.tx_valid = 1'b1;
				res.tx_data  = addr_r;
			end
			i2cms_pkg::ACT_STOP_OK, i2cms_pkg::ACT_ANACK, i2cms_pkg::ACT_DNACK:
				res.bus_cmd = i2cms_pkg::CMD_STOP;
			i2cms_pkg::ACT_TX_DATA: begin
				res.tx_valid = 1'b1;
				res.tx_data  = word.tx_byte;
			end
			i2cms_pkg::ACT_RX_CMD: begin
				// nack the last byte to be read
				if ({1'b0, state.bytes_to_read} > pos_inc_wide)
					res.bus_cmd = i2cms_pkg::CMD_ACK;
				else
					res.bus_cmd = i2cms_pkg::CMD_NACK;
			end
			i2cms_pkg::ACT_RX_BYTE: begin
				res.rx_valid = 1'b1;
				res.rx_data  = word.rx_byte;
				res.rx_index = state.byte_position;
				if (pos_inc == state.bytes_to_read)
					res.bus_cmd = i2cms_pkg::CMD_STOP;
			end
			i2cms_pkg::ACT_STOP_DONE:
				res.done_res = state.active;
			i2cms_pkg::ACT_ERROR: begin
				res.bus_cmd  = i2cms_pkg::CMD_ABORT;
				res.done_res = state.active;
			end
			default: res.bus_cmd = i2cms_pkg::CMD_NONE;
		endcase
		res.position = state_nxt.byte_position;
		res.busy_res = state_nxt.active;
		if (act == i2cms_pkg::ACT_REJECT)
			res.status = i2cms_pkg::ST_BUSY;
		else
			res.status = {1'b0, state_nxt.result_code};
	end

endmodule

// ===== sim/i2c_master_transfer_sequencer_unit_tb.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// i2c_master_transfer_sequencer_unit_tb
// runs directed and random request and bus event words through the
// sequencer and checks every result word against a cycle-free mirror of the
// transfer sequence, with random idling on both channels
// ----------------------------------------------------------------------------
module i2c_master_transfer_sequencer_unit_tb;

	// mirror of the sequence state, advanced once per accepted input word
	class sequencer_mirror;
		i2cms_pkg::phase_t    phase;
		logic                 active;
		logic                 wr_phase_over;
		logic [7:0]           pos;
		i2cms_pkg::res_t      rcode;
		logic [6:0]           dev_addr;
		logic [7:0]           wr_count;
		logic [7:0]           rd_count;
		i2cms_pkg::seq_res_t  due_results[$];
		int unsigned          errors;

		function new();
			phase         = i2cms_pkg::PH_IDLE;
			active        = 1'b0;
			wr_phase_over = 1'b0;
			pos           = '0;
			rcode         = i2cms_pkg::RES_OK;
			dev_addr      = '0;
			wr_count      = '0;
			rd_count      = '0;
			errors        = 0;
		endfunction

		// one step of the transfer sequence
		function i2cms_pkg::seq_res_t step_sequence(i2cms_pkg::seq_in_t w);
			i2cms_pkg::seq_res_t r;
			logic                err;
			logic                fin;
			logic                rej;
			logic [7:0]          addr_byte;
			r = '0;
			err = 1'b0;
			fin = 1'b0;
			rej = 1'b0;
			addr_byte = {dev_addr, i2cms_pkg::RW_WRITE};
			case (w.func)
				i2cms_pkg::FN_START: begin
					if (active) begin
						rej = 1'b1;
					end else begin
						dev_addr      = w.target_address;
						wr_count      = w.write_count;
						rd_count      = w.read_count;
						rcode         = i2cms_pkg::RES_OK;
						pos           = '0;
						active        = 1'b1;
						wr_phase_over = 1'b0;
						if (phase == i2cms_pkg::PH_IDLE
								&& w.bus_state == i2cms_pkg::BS_IDLE
								&& !w.bus_nacked) begin
							phase = i2cms_pkg::PH_START;
							r.bus_cmd = i2cms_pkg::CMD_START;
						end else begin
							err = 1'b1;
						end
					end
				end
				i2cms_pkg::FN_EVENT: begin
					case (phase)
						i2cms_pkg::PH_START: begin
							if (w.bus_state == i2cms_pkg::BS_START && !w.bus_nacked) begin
								if (!wr_phase_over && wr_count != 0) begin
									phase = i2cms_pkg::PH_WADDR;
									r.tx_valid = 1'b1;
									r.tx_data = addr_byte;
								end else if (rd_count != 0) begin
									phase = i2cms_pkg::PH_READ;
									r.flush_rx = 1'b1;
									r.tx_valid = 1'b1;
									r.tx_data = {dev_addr, i2cms_pkg::RW_READ};
								end else begin
									phase = i2cms_pkg::PH_STOP;
									r.bus_cmd = i2cms_pkg::CMD_STOP;
								end
							end else begin
								err = 1'b1;
							end
						end
						i2cms_pkg::PH_WADDR: begin
							if (w.bus_state == i2cms_pkg::BS_ADDR && !w.bus_nacked) begin
							end else if (w.bus_state == i2cms_pkg::BS_ADDRACK
									&& w.bus_nacked) begin
								rcode = i2cms_pkg::RES_ANACK;
								phase = i2cms_pkg::PH_STOP;
								r.bus_cmd = i2cms_pkg::CMD_STOP;
							end else if (w.bus_state == i2cms_pkg::BS_ADDRACK) begin
								phase = i2cms_pkg::PH_WDATA;
								r.tx_valid = 1'b1;
								r.tx_data = w.tx_byte;
								pos = pos + 8'd1;
							end else begin
								err = 1'b1;
							end
						end
						i2cms_pkg::PH_WDATA: begin
							if (w.bus_state == i2cms_pkg::BS_DATA && !w.bus_nacked) begin
							end else if (w.bus_state == i2cms_pkg::BS_DATAACK
									&& w.bus_nacked) begin
								rcode = i2cms_pkg::RES_DNACK;
								phase = i2cms_pkg::PH_STOP;
								r.bus_cmd = i2cms_pkg::CMD_STOP;
							end else if (w.bus_state == i2cms_pkg::BS_DATAACK) begin
								if (pos < wr_count) begin
									r.tx_valid = 1'b1;
									r.tx_data = w.tx_byte;
									pos = pos + 8'd1;
								end else if (rd_count != 0) begin
									wr_phase_over = 1'b1;
									pos = '0;
									phase = i2cms_pkg::PH_START;
									r.bus_cmd = i2cms_pkg::CMD_START;
								end else begin
									rcode = i2cms_pkg::RES_OK;
									phase = i2cms_pkg::PH_STOP;
									r.bus_cmd = i2cms_pkg::CMD_STOP;
								end
							end else begin
								err = 1'b1;
							end
						end
						i2cms_pkg::PH_READ: begin
							if (w.bus_state == i2cms_pkg::BS_ADDR && !w.bus_nacked) begin
							end else if (w.bus_state == i2cms_pkg::BS_ADDRACK
									&& w.bus_nacked) begin
								rcode = i2cms_pkg::RES_ANACK;
								phase = i2cms_pkg::PH_STOP;
								r.bus_cmd = i2cms_pkg::CMD_STOP;
							end else if (w.bus_state == i2cms_pkg::BS_ADDRACK) begin
							end else if (w.bus_state == i2cms_pkg::BS_DATA && !w.bus_nacked) begin
								r.bus_cmd = (int'(rd_count) > int'(pos) + 1)
									? i2cms_pkg::CMD_ACK : i2cms_pkg::CMD_NACK;
							end else if (w.bus_state == i2cms_pkg::BS_DATAACK
									&& !w.bus_nacked) begin
								r.rx_valid = 1'b1;
								r.rx_data = w.rx_byte;
								r.rx_index = pos;
								pos = pos + 8'd1;
								if (pos == rd_count) begin
									rcode = i2cms_pkg::RES_OK;
									phase = i2cms_pkg::PH_STOP;
									r.bus_cmd = i2cms_pkg::CMD_STOP;
								end
							end else begin
								err = 1'b1;
							end
						end
						i2cms_pkg::PH_STOP: begin
							if ((w.bus_state == i2cms_pkg::BS_IDLE && !w.bus_nacked)
									|| w.stop_seen) begin
								phase = i2cms_pkg::PH_IDLE;
								fin = 1'b1;
							end else begin
								err = 1'b1;
							end
						end
						default: err = 1'b1;
					endcase
				end
				default: err = 1'b1;
			endcase

			if (err) begin
				phase = i2cms_pkg::PH_IDLE;
				if (active) begin
					rcode = i2cms_pkg::RES_HANG;
					fin = 1'b1;
				end
				r.bus_cmd  = i2cms_pkg::CMD_ABORT;
				r.tx_valid = 1'b0;
				r.tx_data  = '0;
				r.flush_rx = 1'b0;
			end
			if (fin && active) begin
				active = 1'b0;
				r.done_res = 1'b1;
			end
			r.status   = rej ? i2cms_pkg::ST_BUSY : {1'b0, rcode};
			r.position = pos;
			r.busy_res = active;
			return r;
		endfunction

		function void take_word(i2cms_pkg::seq_in_t w);
			due_results.push_back(step_sequence(w));
		endfunction

		function void cmp_field(string name, int unsigned want, int unsigned got);
			if (want != got) begin
				errors++;
				if (errors <= 100)
					$display("%0t: %s expected %0d got %0d", $time, name, want, got);
			end
		endfunction

		function void check_word(i2cms_pkg::seq_res_t got);
			i2cms_pkg::seq_res_t want;
			if (due_results.size() == 0) begin
				errors++;
				if (errors <= 100)
					$display("%0t: result word with none due, expected none got %h", $time, got);
				return;
			end
			want = due_results.pop_front();
			cmp_field("bus_cmd", want.bus_cmd, got.bus_cmd);
			cmp_field("tx_valid", want.tx_valid, got.tx_valid);
			cmp_field("tx_data", want.tx_data, got.tx_data);
			cmp_field("flush_rx", want.flush_rx, got.flush_rx);
			cmp_field("rx_valid", want.rx_valid, got.rx_valid);
			cmp_field("rx_data", want.rx_data, got.rx_data);
			cmp_field("rx_index", want.rx_index, got.rx_index);
			cmp_field("position", want.position, got.position);
			cmp_field("done_res", want.done_res, got.done_res);
			cmp_field("status", want.status, got.status);
			cmp_field("busy_res", want.busy_res, got.busy_res);
		endfunction
	endclass

	logic       clk = 1'b0;
	logic       arst_n = 1'b0;
	logic       in_valid = 1'b0;
	logic       in_stall;
	logic [1:0] func = '0;
	logic [2:0] bus_state = '0;
	logic       bus_nacked = 1'b0;
	logic       stop_seen = 1'b0;
	logic [6:0] target_address = '0;
	logic [7:0] write_count = '0;
	logic [7:0] read_count = '0;
	logic [7:0] tx_byte = '0;
	logic [7:0] rx_byte = '0;
	logic       out_valid;
	logic       out_stall = 1'b0;
	logic [2:0] bus_cmd;
	logic       tx_valid;
	logic [7:0] tx_data;
	logic       flush_rx;
	logic       rx_valid;
	logic [7:0] rx_data;
	logic [7:0] rx_index;
	logic [7:0] position;
	logic       done_res;
	logic [2:0] status;
	logic       busy_res;

	// set while both sides run with no idling at all
	logic       steady = 1'b0;

	sequencer_mirror         mirror;
	i2cms_pkg::seq_in_t      opening_words[$];

	i2c_master_transfer_sequencer_unit u_top (
		.clk            (clk),
		.arst_n         (arst_n),
		.in_valid       (in_valid),
		.in_stall       (in_stall),
		.func           (func),
		.bus_state      (bus_state),
		.bus_nacked     (bus_nacked),
		.stop_seen      (stop_seen),
		.target_address (target_address),
		.write_count    (write_count),
		.read_count     (read_count),
		.tx_byte        (tx_byte),
		.rx_byte        (rx_byte),
		.out_valid      (out_valid),
		.out_stall      (out_stall),
		.bus_cmd        (bus_cmd),
		.tx_valid       (tx_valid),
		.tx_data        (tx_data),
		.flush_rx       (flush_rx),
		.rx_valid       (rx_valid),
		.rx_data        (rx_data),
		.rx_index       (rx_index),
		.position       (position),
		.done_res       (done_res),
		.status         (status),
		.busy_res       (busy_res)
	);

	always #2 clk = ~clk;

	// result side stalls at random, except in the steady stretch
	always @(negedge clk) begin
		out_stall <= !steady && ($urandom_range(99) < 28);
	end

	// every result word taken at this edge goes to the mirror
	always @(posedge clk) begin
		if (arst_n && out_valid && !out_stall)
			mirror.check_word({bus_cmd, tx_valid, tx_data, flush_rx, rx_valid, rx_data,
				rx_index, position, done_res, status, busy_res});
	end

	function automatic i2cms_pkg::seq_in_t mk(i2cms_pkg::func_t f, logic [2:0] bs,
			logic nk, logic ss, logic [6:0] addr, logic [7:0] wc, logic [7:0] rc,
			logic [7:0] txb, logic [7:0] rxb);
		i2cms_pkg::seq_in_t w;
		w.func           = f;
		w.bus_state      = bs;
		w.bus_nacked     = nk;
		w.stop_seen      = ss;
		w.target_address = addr;
		w.write_count    = wc;
		w.read_count     = rc;
		w.tx_byte        = txb;
		w.rx_byte        = rxb;
		return w;
	endfunction

	// mostly tiny transfers, now and then up to the full byte count
	function automatic logic [7:0] pick_count();
		if ($urandom_range(99) < 3)
			return 8'($urandom_range(255));
		return 8'($urandom_range(4));
	endfunction

	// behaves like a well-mannered peripheral most of the time, with some
	// aborts, rejected starts and plain noise mixed in
	function automatic i2cms_pkg::seq_in_t next_bus_word();
		i2cms_pkg::seq_in_t w;
		int unsigned        roll;
		int unsigned        pick;
		w.func           = i2cms_pkg::FN_EVENT;
		w.bus_state      = i2cms_pkg::BS_IDLE;
		w.bus_nacked     = 1'b0;
		w.stop_seen      = 1'b0;
		w.target_address = 7'($urandom_range(127));
		w.write_count    = 8'($urandom_range(255));
		w.read_count     = 8'($urandom_range(255));
		w.tx_byte        = 8'($urandom_range(255));
		w.rx_byte        = 8'($urandom_range(255));
		roll = $urandom_range(99);
		pick = $urandom_range(39);
		if (roll < 8) begin
			w.func       = 2'($urandom_range(3));
			w.bus_state  = 3'($urandom_range(7));
			w.bus_nacked = 1'($urandom_range(1));
			w.stop_seen  = 1'($urandom_range(1));
		end else if (roll < 10) begin
			w.func = ($urandom_range(1) != 0) ? i2cms_pkg::FN_ABORT : i2cms_pkg::FN_RSVD;
		end else if (roll < 12 && mirror.active) begin
			w.func = i2cms_pkg::FN_START;
		end else if (!mirror.active) begin
			w.func        = i2cms_pkg::FN_START;
			w.write_count = pick_count();
			w.read_count  = pick_count();
		end else begin
			case (mirror.phase)
				i2cms_pkg::PH_START: w.bus_state = i2cms_pkg::BS_START;
				i2cms_pkg::PH_WADDR: begin
					w.bus_state  = (pick < 8) ? i2cms_pkg::BS_ADDR : i2cms_pkg::BS_ADDRACK;
					w.bus_nacked = (pick == 39);
				end
				i2cms_pkg::PH_WDATA: begin
					w.bus_state  = (pick < 8) ? i2cms_pkg::BS_DATA : i2cms_pkg::BS_DATAACK;
					w.bus_nacked = (pick == 39);
				end
				i2cms_pkg::PH_READ: begin
					if (pick == 0)
						w.bus_state = i2cms_pkg::BS_ADDR;
					else if (pick < 3)
						w.bus_state = i2cms_pkg::BS_ADDRACK;
					else if (pick < 20)
						w.bus_state = i2cms_pkg::BS_DATA;
					else
						w.bus_state = i2cms_pkg::BS_DATAACK;
					w.bus_nacked = (pick == 2);
				end
				i2cms_pkg::PH_STOP: begin
					if ($urandom_range(1) != 0) begin
						w.stop_seen = 1'($urandom_range(1));
					end else begin
						w.stop_seen  = 1'b1;
						w.bus_state  = 3'($urandom_range(7));
						w.bus_nacked = 1'($urandom_range(1));
					end
				end
				default: w.bus_state = 3'($urandom_range(7));
			endcase
		end
		return w;
	endfunction

	task automatic drive_word(i2cms_pkg::seq_in_t w);
		func           <= w.func;
		bus_state      <= w.bus_state;
		bus_nacked     <= w.bus_nacked;
		stop_seen      <= w.stop_seen;
		target_address <= w.target_address;
		write_count    <= w.write_count;
		read_count     <= w.read_count;
		tx_byte        <= w.tx_byte;
		rx_byte        <= w.rx_byte;
	endtask

	// entered and left at a falling edge
	task automatic send_word(i2cms_pkg::seq_in_t w);
		while (!steady && $urandom_range(99) < 28) begin
			in_valid <= 1'b0;
			@(negedge clk);
		end
		in_valid <= 1'b1;
		drive_word(w);
		do
			@(posedge clk);
		while (in_stall);
		mirror.take_word(w);
		@(negedge clk);
	endtask

	// sender holds off until every result word due has arrived
	task automatic hold_until_drained();
		in_valid <= 1'b0;
		@(negedge clk);
		while (mirror.due_results.size() != 0)
			@(negedge clk);
	endtask

	initial begin
		// no transfer yet: event, abort and the reserved code all abort quietly
		opening_words.push_back(mk(i2cms_pkg::FN_EVENT, i2cms_pkg::BS_START, 1'b0, 1'b0,
			7'h00, 8'd0, 8'd0, 8'h00, 8'h00));
		opening_words.push_back(mk(i2cms_pkg::FN_ABORT, i2cms_pkg::BS_IDLE, 1'b0, 1'b0,
			7'h00, 8'd0, 8'd0, 8'h00, 8'h00));
		opening_words.push_back(mk(i2cms_pkg::FN_RSVD, i2cms_pkg::BS_IDLE, 1'b0, 1'b0,
			7'h00, 8'd0, 8'd0, 8'h00, 8'h00));
		// start with the bus not idle, and with idle but nacked: bus hang
		opening_words.push_back(mk(i2cms_pkg::FN_START, i2cms_pkg::BS_ADDR, 1'b0, 1'b0,
			7'h55, 8'd2, 8'd2, 8'h00, 8'h00));
		opening_words.push_back(mk(i2cms_pkg::FN_START, i2cms_pkg::BS_IDLE, 1'b1, 1'b0,
			7'h2a, 8'd1, 8'd1, 8'h00, 8'h00));
		// full write then read of one byte each, top address
		opening_words.push_back(mk(i2cms_pkg::FN_START, i2cms_pkg::BS_IDLE, 1'b0, 1'b0,
			7'h7f, 8'd1, 8'd1, 8'h00, 8'h00));
		// start while busy is rejected
		opening_words.push_back(mk(i2cms_pkg::FN_START, i2cms_pkg::BS_IDLE, 1'b0, 1'b0,
			7'h00, 8'd255, 8'd255, 8'h00, 8'h00));
		opening_words.push_back(mk(i2cms_pkg::FN_EVENT, i2cms_pkg::BS_START, 1'b0, 1'b0,
			7'h00, 8'd0, 8'd0, 8'h00, 8'h00));
		opening_words.push_back(mk(i2cms_pkg::FN_EVENT, i2cms_pkg::BS_ADDR, 1'b0, 1'b0,
			7'h00, 8'd0, 8'd0, 8'h00, 8'h00));
		opening_words.push_back(mk(i2cms_pkg::FN_EVENT, i2cms_pkg::BS_ADDRACK, 1'b0, 1'b0,
			7'h00, 8'd0, 8'd0, 8'hff, 8'h00));
		opening_words.push_back(mk(i2cms_pkg::FN_EVENT, i2cms_pkg::BS_DATA, 1'b0, 1'b0,
			7'h00, 8'd0, 8'd0, 8'h00, 8'h00));
		// last write byte acked with reads to come: repeated start
		opening_words.push_back(mk(i2cms_pkg::FN_EVENT, i2cms_pkg::BS_DATAACK, 1'b0, 1'b0,
			7'h00, 8'd0, 8'd0, 8'h00, 8'h00));
		opening_words.push_back(mk(i2cms_pkg::FN_EVENT, i2cms_pkg::BS_START, 1'b0, 1'b0,
			7'h00, 8'd0, 8'd0, 8'h00, 8'h00));
		opening_words.push_back(mk(i2cms_pkg::FN_EVENT, i2cms_pkg::BS_ADDR, 1'b0, 1'b0,
			7'h00, 8'd0, 8'd0, 8'h00, 8'h00));
		opening_words.push_back(mk(i2cms_pkg::FN_EVENT, i2cms_pkg::BS_ADDRACK, 1'b0, 1'b0,
			7'h00, 8'd0, 8'd0, 8'h00, 8'h00));
		opening_words.push_back(mk(i2cms_pkg::FN_EVENT, i2cms_pkg::BS_DATA, 1'b0, 1'b0,
			7'h00, 8'd0, 8'd0, 8'h00, 8'h00));
		opening_words.push_back(mk(i2cms_pkg::FN_EVENT, i2cms_pkg::BS_DATAACK, 1'b0, 1'b0,
			7'h00, 8'd0, 8'd0, 8'h00, 8'hff));
		// stop flag ends the stop phase whatever the bus state says
		opening_words.push_back(mk(i2cms_pkg::FN_EVENT, i2cms_pkg::BS_ADDRACK, 1'b1, 1'b1,
			7'h00, 8'd0, 8'd0, 8'h00, 8'h00));
		// empty transfer straight to stop, then a wrong stop event: hang
		opening_words.push_back(mk(i2cms_pkg::FN_START, i2cms_pkg::BS_IDLE, 1'b0, 1'b0,
			7'h00, 8'd0, 8'd0, 8'h00, 8'h00));
		opening_words.push_back(mk(i2cms_pkg::FN_EVENT, i2cms_pkg::BS_START, 1'b0, 1'b0,
			7'h00, 8'd0, 8'd0, 8'h00, 8'h00));
		opening_words.push_back(mk(i2cms_pkg::FN_EVENT, i2cms_pkg::BS_IDLE, 1'b1, 1'b0,
			7'h00, 8'd0, 8'd0, 8'h00, 8'h00));
		// address nack
		opening_words.push_back(mk(i2cms_pkg::FN_START, i2cms_pkg::BS_IDLE, 1'b0, 1'b0,
			7'h05, 8'd2, 8'd0, 8'h00, 8'h00));
		opening_words.push_back(mk(i2cms_pkg::FN_EVENT, i2cms_pkg::BS_START, 1'b0, 1'b0,
			7'h00, 8'd0, 8'd0, 8'h00, 8'h00));
		opening_words.push_back(mk(i2cms_pkg::FN_EVENT, i2cms_pkg::BS_ADDRACK, 1'b1, 1'b0,
			7'h00, 8'd0, 8'd0, 8'h00, 8'h00));
		opening_words.push_back(mk(i2cms_pkg::FN_EVENT, i2cms_pkg::BS_IDLE, 1'b0, 1'b0,
			7'h00, 8'd0, 8'd0, 8'h00, 8'h00));
		// data nack
		opening_words.push_back(mk(i2cms_pkg::FN_START, i2cms_pkg::BS_IDLE, 1'b0, 1'b0,
			7'h09, 8'd1, 8'd0, 8'h00, 8'h00));
		opening_words.push_back(mk(i2cms_pkg::FN_EVENT, i2cms_pkg::BS_START, 1'b0, 1'b0,
			7'h00, 8'd0, 8'd0, 8'h00, 8'h00));
		opening_words.push_back(mk(i2cms_pkg::FN_EVENT, i2cms_pkg::BS_ADDRACK, 1'b0, 1'b0,
			7'h00, 8'd0, 8'd0, 8'h3c, 8'h00));
		opening_words.push_back(mk(i2cms_pkg::FN_EVENT, i2cms_pkg::BS_DATAACK, 1'b1, 1'b0,
			7'h00, 8'd0, 8'd0, 8'h00, 8'h00));
		opening_words.push_back(mk(i2cms_pkg::FN_EVENT, 3'd7, 1'b0, 1'b1,
			7'h00, 8'd0, 8'd0, 8'h00, 8'h00));
	end

	initial begin
		mirror = new();
		repeat (11) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;
		@(negedge clk);

		foreach (opening_words[i])
			send_word(opening_words[i]);
		hold_until_drained();

		for (int n = 0; n < 1550; n++) begin
			// now and then let the pipeline empty completely
			if (n % 500 == 250)
				hold_until_drained();
			steady = (n >= 700 && n < 900);
			send_word(next_bus_word());
		end
		steady = 1'b0;

		hold_until_drained();
		repeat (8) @(posedge clk);
		if (mirror.errors == 0 && mirror.due_results.size() == 0)
			$display("i2c_master_transfer_sequencer_unit_tb: clean");
		else
			$display("i2c_master_transfer_sequencer_unit_tb: errors");
		$finish;
	end

	// watchdog, far beyond the slowest correct run
	initial begin
		#4000000;
		$display("i2c_master_transfer_sequencer_unit_tb: errors");
		$finish;
	end

endmodule
